[src/triangle_strip_builder_top_assert.svh]
// ---------------------------------------------------------------------------
// triangle strip builder assertion macros
// shared property forms for the port checker
// ---------------------------------------------------------------------------
`ifndef TRIANGLE_STRIP_BUILDER_TOP_ASSERT_SVH
`define TRIANGLE_STRIP_BUILDER_TOP_ASSERT_SVH

// condition implies consequence in the same cycle
`define TSB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// condition implies consequence in the next cycle
`define TSB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/tsb_pkg.sv]
// ---------------------------------------------------------------------------
// tsb_pkg
// widths, constants and request types shared by the strip builder modules
// ---------------------------------------------------------------------------
package tsb_pkg;

  localparam int VERTEX_ID_BITS = 20;
  localparam int STRIP_LEN_BITS = 16;
  localparam int COUNT_BITS     = 24;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  typedef logic [VERTEX_ID_BITS-1:0] vid_t;
  typedef logic [STRIP_LEN_BITS-1:0] slen_t;
  typedef logic [COUNT_BITS-1:0]     count_t;
  typedef logic [QUEUE_PTR_BITS-1:0] qptr_t;
  typedef logic [QUEUE_CNT_BITS-1:0] qcnt_t;

  localparam slen_t  STRIP_BASE_LEN = slen_t'(3);
  localparam slen_t  SLEN_MAX       = '1;
  localparam count_t COUNT_MAX      = '1;
  localparam count_t START_ADD      = count_t'(3);
  localparam count_t CONT_ADD       = count_t'(1);
  localparam qcnt_t  QUEUE_FULL_CNT = qcnt_t'(QUEUE_DEPTH);

  typedef struct packed {
    vid_t first;
    vid_t second;
    vid_t third;
  } tri_t;

  // one emit request from front to back
  typedef struct packed {
    tri_t  face;
    logic  strip_start;
    logic  strip_end;
    slen_t strip_len;
    logic  mesh_end;
  } emit_req_t;

  typedef struct packed {
    logic      push;
    emit_req_t req;
  } push_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } queue_status_t;

endpackage

[src/tsb_front.sv]
// ---------------------------------------------------------------------------
// tsb_front
// holds one triangle, runs the edge-sharing test and issues emit requests
// ---------------------------------------------------------------------------
module tsb_front
  import tsb_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  vid_t          vertex_a,
  input  vid_t          vertex_b,
  input  vid_t          vertex_c,
  input  logic          last_triangle,
  input  queue_status_t q_status,
  output push_t         q_push
);

  tri_t  held;
  logic  held_valid;
  logic  held_starts_strip;
  slen_t strip_length;
  logic  flush_pend;

  tri_t  new_tri;
  tri_t  jf_h;
  tri_t  jf_n;
  logic  jf_ok;
  tri_t  jn_n;
  logic  jn_ok;
  tri_t  emit_h;
  tri_t  keep_n;
  logic  joined;
  logic  in_fire;
  logic  flush_fire;

  assign new_tri    = '{first: vertex_a, second: vertex_b, third: vertex_c};
  assign in_stall   = q_status.full | flush_pend;
  assign in_fire    = in_valid & ~in_stall;
  assign flush_fire = flush_pend & ~q_status.full;

  // opening test, both triangles may rotate
  always_comb begin
    vid_t a, b, c, d, e, f;
    a = held.first;  b = held.second;  c = held.third;
    d = vertex_a;    e = vertex_b;     f = vertex_c;
    jf_ok = 1'b1;
    jf_h  = held;
    jf_n  = new_tri;
    priority if (a == d) begin
      if (b == f) begin
        jf_h = '{c, a, b}; jf_n = '{a, b, e};
      end else if (c == e) begin
        jf_h = '{b, c, a}; jf_n = '{c, a, f};
      end else begin
        jf_ok = 1'b0;
      end
    end else if (a == e) begin
      if (b == d) begin
        jf_h = '{c, a, b}; jf_n = '{a, b, f};
      end else if (c == f) begin
        jf_h = '{b, c, a}; jf_n = '{c, a, d};
      end else begin
        jf_ok = 1'b0;
      end
    end else if (a == f) begin
      if (b == e) begin
        jf_h = '{c, a, b}; jf_n = '{a, b, d};
      end else if (c == d) begin
        jf_h = '{b, c, a}; jf_n = '{c, a, e};
      end else begin
        jf_ok = 1'b0;
      end
    end else if (b == d && c == f) begin
      jf_n = '{b, c, e};
    end else if (b == e && c == d) begin
      jf_n = '{b, c, f};
    end else if (b == f && c == e) begin
      jf_n = '{b, c, d};
    end else begin
      jf_ok = 1'b0;
    end
  end

  // continuation test, new triangle must carry held second and third
  always_comb begin
    vid_t b, c, d, e, f;
    b = held.second; c = held.third;
    d = vertex_a;    e = vertex_b;   f = vertex_c;
    jn_ok = 1'b1;
    jn_n  = new_tri;
    priority if (b == d) begin
      if (c == e) begin
        jn_n = new_tri;
      end else if (c == f) begin
        jn_n = '{b, c, e};
      end else begin
        jn_ok = 1'b0;
      end
    end else if (b == e) begin
      if (c == d) begin
        jn_n = '{b, c, f};
      end else if (c == f) begin
        jn_n = '{b, c, d};
      end else begin
        jn_ok = 1'b0;
      end
    end else if (b == f) begin
      if (c == d) begin
        jn_n = '{b, c, e};
      end else if (c == e) begin
        jn_n = '{b, c, d};
      end else begin
        jn_ok = 1'b0;
      end
    end else begin
      jn_ok = 1'b0;
    end
  end

  always_comb begin
    joined = held_starts_strip ? jf_ok : jn_ok;
    emit_h = held_starts_strip ? jf_h : held;
    if (!held_valid) begin
      keep_n = new_tri;
    end else begin
      keep_n = held_starts_strip ? jf_n : jn_n;
    end
  end

  always_comb begin
    q_push = '0;
    if (flush_fire) begin
      q_push.push            = 1'b1;
      q_push.req.face        = held;
      q_push.req.strip_start = held_starts_strip;
      q_push.req.strip_end   = 1'b1;
      q_push.req.strip_len   = strip_length;
      q_push.req.mesh_end    = 1'b1;
    end else if (in_fire && held_valid) begin
      q_push.push            = 1'b1;
      q_push.req.face        = emit_h;
      q_push.req.strip_start = held_starts_strip;
      q_push.req.strip_end   = ~joined;
      q_push.req.strip_len   = strip_length;
      q_push.req.mesh_end    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid        <= 1'b0;
      held_starts_strip <= 1'b1;
      strip_length      <= STRIP_BASE_LEN;
      flush_pend        <= 1'b0;
    end else if (flush_fire) begin
      held_valid        <= 1'b0;
      held_starts_strip <= 1'b1;
      strip_length      <= STRIP_BASE_LEN;
      flush_pend        <= 1'b0;
    end else if (in_fire) begin
      held_valid <= 1'b1;
      flush_pend <= last_triangle;
      if (held_valid && joined) begin
        held_starts_strip <= 1'b0;
        if (strip_length != SLEN_MAX) begin
          strip_length <= strip_length + 1'b1;
        end
      end else begin
        held_starts_strip <= 1'b1;
        strip_length      <= STRIP_BASE_LEN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      held <= keep_n;
    end
  end

endmodule

[src/tsb_queue.sv]
// ---------------------------------------------------------------------------
// tsb_queue
// short request queue between the front and the back
// ---------------------------------------------------------------------------
module tsb_queue
  import tsb_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  push_t         q_push,
  input  logic          pop,
  output emit_req_t     head,
  output queue_status_t q_status
);

  emit_req_t store [QUEUE_DEPTH];
  qptr_t     wr_ptr;
  qptr_t     rd_ptr;
  qcnt_t     count;
  logic      do_push;
  logic      do_pop;

  assign q_status.full     = (count == QUEUE_FULL_CNT);
  assign q_status.nonempty = (count != '0);
  assign do_push           = q_push.push & ~q_status.full;
  assign do_pop            = pop & q_status.nonempty;
  assign head              = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= q_push.req;
    end
  end

endmodule

[src/tsb_back.sv]
// ---------------------------------------------------------------------------
// tsb_back
// applies running mesh totals and holds the result register
// ---------------------------------------------------------------------------
module tsb_back
  import tsb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  emit_req_t head,
  input  logic      head_valid,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output vid_t      out_first,
  output vid_t      out_second,
  output vid_t      out_third,
  output logic      strip_start,
  output logic      strip_end,
  output slen_t     strip_len,
  output logic      mesh_end,
  output count_t    total_vertices,
  output count_t    face_count,
  output vid_t      max_vertex_id
);

  count_t vertex_total;
  count_t faces_seen;
  vid_t   largest_id;

  count_t vertex_total_next;
  count_t faces_seen_next;
  vid_t   largest_id_next;
  count_t add;
  vid_t   max_ab;
  vid_t   max_abc;

  assign pop = head_valid & (~out_valid | ~out_stall);

  always_comb begin
    add = head.strip_start ? START_ADD : CONT_ADD;
    vertex_total_next = (vertex_total > COUNT_MAX - add) ? COUNT_MAX : vertex_total + add;
    faces_seen_next   = (faces_seen != COUNT_MAX) ? faces_seen + 1'b1 : faces_seen;
    max_ab  = (head.face.first > head.face.second) ? head.face.first : head.face.second;
    max_abc = (max_ab > head.face.third) ? max_ab : head.face.third;
    largest_id_next = (max_abc > largest_id) ? max_abc : largest_id;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      vertex_total <= '0;
      faces_seen   <= '0;
      largest_id   <= '0;
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
        if (head.mesh_end) begin
          vertex_total <= '0;
          faces_seen   <= '0;
          largest_id   <= '0;
        end else begin
          vertex_total <= vertex_total_next;
          faces_seen   <= faces_seen_next;
          largest_id   <= largest_id_next;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_first      <= head.face.first;
      out_second     <= head.face.second;
      out_third      <= head.face.third;
      strip_start    <= head.strip_start;
      strip_end      <= head.strip_end;
      strip_len      <= head.strip_len;
      mesh_end       <= head.mesh_end;
      total_vertices <= vertex_total_next;
      face_count     <= faces_seen_next;
      max_vertex_id  <= largest_id_next;
    end
  end

endmodule

[src/triangle_strip_builder_top.sv]
// ---------------------------------------------------------------------------
// triangle_strip_builder_top
// greedy triangle strip builder with per-mesh running totals
// ---------------------------------------------------------------------------
// Takes one triangle request per cycle while in_stall is low. Each triangle
// is held until the next one shows whether the two share an edge, so a
// result appears one request later, through a four-entry queue and the
// output register. After the final triangle of a mesh the front takes no
// input until it has pushed the held triangle as the closing result, which
// waits for room in the queue; the queue takes one entry per cycle while
// not full. Totals return to zero after the result marked mesh_end.
module triangle_strip_builder_top
  import tsb_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_stall,
  input  vid_t   vertex_a,
  input  vid_t   vertex_b,
  input  vid_t   vertex_c,
  input  logic   last_triangle,
  output logic   out_valid,
  input  logic   out_stall,
  output vid_t   out_first,
  output vid_t   out_second,
  output vid_t   out_third,
  output logic   strip_start,
  output logic   strip_end,
  output slen_t  strip_len,
  output logic   mesh_end,
  output count_t total_vertices,
  output count_t face_count,
  output vid_t   max_vertex_id
);

  push_t         q_push;
  queue_status_t q_status;
  emit_req_t     head;
  logic          pop;

  tsb_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .vertex_a      (vertex_a),
    .vertex_b      (vertex_b),
    .vertex_c      (vertex_c),
    .last_triangle (last_triangle),
    .q_status      (q_status),
    .q_push        (q_push)
  );

  tsb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .q_push   (q_push),
    .pop      (pop),
    .head     (head),
    .q_status (q_status)
  );

  tsb_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .head_valid     (q_status.nonempty),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_first      (out_first),
    .out_second     (out_second),
    .out_third      (out_third),
    .strip_start    (strip_start),
    .strip_end      (strip_end),
    .strip_len      (strip_len),
    .mesh_end       (mesh_end),
    .total_vertices (total_vertices),
    .face_count     (face_count),
    .max_vertex_id  (max_vertex_id)
  );

endmodule

[src/tsb_checker.sv]
// ---------------------------------------------------------------------------
// tsb_checker
// port-level checks on the strip builder results
// ---------------------------------------------------------------------------
`include "triangle_strip_builder_top_assert.svh"

module tsb_checker
  import tsb_pkg::*;
(
  input logic   clk,
  input logic   rst,
  input logic   out_valid,
  input logic   out_stall,
  input vid_t   out_first,
  input vid_t   out_second,
  input vid_t   out_third,
  input logic   strip_start,
  input logic   strip_end,
  input slen_t  strip_len,
  input logic   mesh_end,
  input count_t total_vertices,
  input count_t face_count,
  input vid_t   max_vertex_id
);

  logic out_hold;
  logic start_shown;
  logic max_ok;
  logic totals_ok;

  assign out_hold    = out_valid & out_stall;
  assign start_shown = out_valid & strip_start;
  assign max_ok      = (max_vertex_id >= out_first) && (max_vertex_id >= out_second) &&
                       (max_vertex_id >= out_third);
  assign totals_ok   = (face_count != '0) && (total_vertices >= START_ADD);

  `TSB_ASSERT_NEXT(a_out_hold, out_hold, out_valid && $stable({out_third, face_count}), "result moved")
  `TSB_ASSERT_NOW(a_start_len, start_shown, strip_len == STRIP_BASE_LEN, "bad start length")
  `TSB_ASSERT_NOW(a_mesh_closes, out_valid && mesh_end, strip_end, "mesh end without strip end")
  `TSB_ASSERT_NOW(a_max_id, out_valid, max_ok, "largest id below emitted id")
  `TSB_ASSERT_NOW(a_faces, out_valid, totals_ok, "totals not counting result")

endmodule

bind triangle_strip_builder_top tsb_checker u_tsb_checker (.*);
